// File: rtl/cba_pkg.sv
// ----------------------------------------------------------------------------
// cba_pkg
// Shared types and constants of the contiguous block allocator.
// ----------------------------------------------------------------------------
package cba_pkg;

   localparam int NUM_BLOCKS = 1024;
   localparam int IDX_W      = $clog2(NUM_BLOCKS);
   localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);
   localparam int SIZE_W     = 32;
   localparam int BS_W       = 25;
   localparam int BYTES_W    = 40;
   localparam int SERIAL_W   = 32;
   localparam int HEAD_W     = SIZE_W + 1;
   localparam int DIV_STEPS  = SIZE_W;
   localparam int DSTEP_W    = $clog2(DIV_STEPS);

   localparam logic [BS_W-1:0]    BLOCK_SIZE_RESET = BS_W'(65536);
   localparam logic [BYTES_W-1:0] BYTES_MAX        = {BYTES_W{1'b1}};

   typedef enum logic [0:0] {
      CSR_BLOCK_SIZE  = 1'b0,
      CSR_POOL_BLOCKS = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_ZERO_SIZE  = 2'd1,
      STATUS_NO_FIT     = 2'd2,
      STATUS_BAD_HANDLE = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HEAD_CHK,
      ST_DIV,
      ST_SCAN,
      ST_MARK,
      ST_RELEASE,
      ST_COUNT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic             start;
      logic [SIZE_W-1:0] dividend;
      logic [BS_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [SIZE_W-1:0] quotient;
   } div_rsp_type;

endpackage

// File: rtl/cba_ram.sv
// ----------------------------------------------------------------------------
// cba_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module cba_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/cba_div.sv
// ----------------------------------------------------------------------------
// cba_div
// Iterative restoring divider, one quotient bit per cycle, rounding up.
// ----------------------------------------------------------------------------
module cba_div
(
   input  logic                 clock,
   input  logic                 reset,
   input  cba_pkg::div_req_type req,
   output cba_pkg::div_rsp_type rsp
);
   import cba_pkg::*;

   logic [SIZE_W-1:0]  q_ff, q_in;
   logic [BS_W:0]      r_ff, r_in;
   logic [BS_W-1:0]    d_ff, d_in;
   logic [DSTEP_W-1:0] step_ff, step_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [BS_W:0]      r_shift;
   logic [BS_W+1:0]    diff;

   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      r_shift = {r_ff[BS_W-1:0], q_ff[SIZE_W-1]};
      diff    = {1'b0, r_shift} - {2'b00, d_ff};
      if (req.start) begin
         q_in    = req.dividend;
         r_in    = '0;
         d_in    = (req.divisor == '0) ? BS_W'(1) : req.divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract when it fits
         if (!diff[BS_W+1]) begin
            r_in = diff[BS_W:0];
            q_in = {q_ff[SIZE_W-2:0], 1'b1};
         end else begin
            r_in = r_shift;
            q_in = {q_ff[SIZE_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == DSTEP_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      q_ff    <= q_in;
      r_ff    <= r_in;
      d_ff    <= d_in;
      step_ff <= step_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = q_ff + SIZE_W'(r_ff != '0);

endmodule

// File: rtl/contiguous_block_allocator.sv
// ----------------------------------------------------------------------------
// contiguous_block_allocator
// First-fit allocator over a pool of equal blocks, flags held in block RAMs.
// ----------------------------------------------------------------------------
// Steps: a division (after a head check for a free; none for a zero size),
//   then a first-fit scan over up to pool_blocks flags, a mark of the run
//   found or a release of the freed run up to the end of the flag RAM, and a
//   free count scan over the pool_blocks flags.
// Throughput: one item at a time; the next is taken once the result is loaded.
// Reset: a clearing pass zeroes all NUM_BLOCKS entries of both RAMs; items stall, csr writes go.
module contiguous_block_allocator
(
   input  logic                         clock,
   input  logic                         reset,
   // item input
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_command,
   input  logic [31:0]                  req_request_size,
   input  logic [cba_pkg::IDX_W-1:0]    req_handle_index,
   // result output
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_status,
   output logic [cba_pkg::IDX_W-1:0]    rsp_start_block,
   output logic [31:0]                  rsp_allocation_number,
   output logic [cba_pkg::CNT_W-1:0]    rsp_free_block_count,
   output logic [39:0]                  rsp_bytes_allocated,
   output logic [39:0]                  rsp_bytes_peak,
   output logic [31:0]                  rsp_alloc_total,
   output logic [31:0]                  rsp_free_total,
   // register writes
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic                         csr_index,
   input  logic [24:0]                  csr_data
);
   import cba_pkg::*;

   state_type            state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [SIZE_W-1:0]    size_ff, size_in;
   logic [IDX_W-1:0]     handle_ff, handle_in;
   logic [BS_W-1:0]      bs_ff;
   logic [CNT_W-1:0]     pool_ff;
   logic [SIZE_W-1:0]    need_ff, need_in;
   logic [CNT_W-1:0]     wa_ff, wa_in;
   logic [CNT_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic                 pend_ff, pend_in;
   logic [IDX_W-1:0]     chk_idx_ff, chk_idx_in;
   logic [CNT_W-1:0]     run_ff, run_in;
   logic [CNT_W-1:0]     free_cnt_ff, free_cnt_in;
   status_type           status_ff, status_in;
   logic [IDX_W-1:0]     start_ff, start_in;
   logic [SERIAL_W-1:0]  serial_ff, serial_in;
   logic [BYTES_W-1:0]   bytes_ff, bytes_in;
   logic [BYTES_W-1:0]   peak_ff, peak_in;
   logic [SERIAL_W-1:0]  alloc_cnt_ff, alloc_cnt_in;
   logic [SERIAL_W-1:0]  free_tot_ff, free_tot_in;
   logic [SERIAL_W-1:0]  next_serial_ff, next_serial_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]     rsp_start_ff, rsp_start_in;
   logic [SERIAL_W-1:0]  rsp_serial_ff, rsp_serial_in;
   logic [CNT_W-1:0]     rsp_free_ff, rsp_free_in;
   logic [BYTES_W-1:0]   rsp_bytes_ff, rsp_bytes_in;
   logic [BYTES_W-1:0]   rsp_peak_ff, rsp_peak_in;
   logic [SERIAL_W-1:0]  rsp_alloc_ff, rsp_alloc_in;
   logic [SERIAL_W-1:0]  rsp_ftot_ff, rsp_ftot_in;

   // busy flag RAM and head RAM ({head, recorded size})
   logic                 busy_we, busy_wd, busy_rd;
   logic [IDX_W-1:0]     busy_wa, busy_ra;
   logic                 head_we;
   logic [HEAD_W-1:0]    head_wd, head_rd;
   logic [IDX_W-1:0]     head_wa, head_ra;

   div_req_type          div_req;
   div_rsp_type          div_rsp;

   logic [CNT_W-1:0]     pool_eff;
   logic [CNT_W-1:0]     run_next;
   logic [CNT_W-1:0]     start_calc;
   logic [BYTES_W:0]     bytes_sum;
   logic                 out_free;

   cba_ram #(.WIDTH(1), .DEPTH(NUM_BLOCKS)) u_busy_ram (
      .clock   (clock),
      .wr_en   (busy_we),
      .wr_addr (busy_wa),
      .wr_data (busy_wd),
      .rd_addr (busy_ra),
      .rd_data (busy_rd)
   );

   cba_ram #(.WIDTH(HEAD_W), .DEPTH(NUM_BLOCKS)) u_head_ram (
      .clock   (clock),
      .wr_en   (head_we),
      .wr_addr (head_wa),
      .wr_data (head_wd),
      .rd_addr (head_ra),
      .rd_data (head_rd)
   );

   cba_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign pool_eff   = (pool_ff > CNT_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : pool_ff;
   assign run_next   = busy_rd ? '0 : run_ff + 1'b1;
   assign start_calc = {1'b0, chk_idx_ff} + 1'b1 - run_next;
   assign bytes_sum  = {1'b0, bytes_ff} + {{(BYTES_W + 1 - SIZE_W){1'b0}}, size_ff};
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      size_in        = size_ff;
      handle_in      = handle_ff;
      need_in        = need_ff;
      wa_in          = wa_ff;
      rd_ptr_in      = rd_ptr_ff;
      pend_in        = 1'b0;
      chk_idx_in     = chk_idx_ff;
      run_in         = run_ff;
      free_cnt_in    = free_cnt_ff;
      status_in      = status_ff;
      start_in       = start_ff;
      serial_in      = serial_ff;
      bytes_in       = bytes_ff;
      peak_in        = peak_ff;
      alloc_cnt_in   = alloc_cnt_ff;
      free_tot_in    = free_tot_ff;
      next_serial_in = next_serial_ff;

      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_start_in   = rsp_start_ff;
      rsp_serial_in  = rsp_serial_ff;
      rsp_free_in    = rsp_free_ff;
      rsp_bytes_in   = rsp_bytes_ff;
      rsp_peak_in    = rsp_peak_ff;
      rsp_alloc_in   = rsp_alloc_ff;
      rsp_ftot_in    = rsp_ftot_ff;

      busy_we  = 1'b0;
      busy_wa  = wa_ff[IDX_W-1:0];
      busy_wd  = 1'b0;
      busy_ra  = rd_ptr_ff[IDX_W-1:0];
      head_we  = 1'b0;
      head_wa  = wa_ff[IDX_W-1:0];
      head_wd  = '0;
      head_ra  = req_handle_index;

      div_req.start    = 1'b0;
      div_req.dividend = size_ff;
      div_req.divisor  = bs_ff;

      req_stall = (state_ff != ST_IDLE);

      unique case (state_ff)
         ST_CLEAR: begin
            // zero one entry of each RAM per cycle
            busy_we = 1'b1;
            head_we = 1'b1;
            wa_in   = wa_ff + 1'b1;
            if (wa_ff == CNT_W'(NUM_BLOCKS - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               cmd_in    = cmd_type'(req_command);
               size_in   = req_request_size;
               handle_in = req_handle_index;
               status_in = STATUS_OK;
               start_in  = '0;
               serial_in = '0;
               if (cmd_type'(req_command) == CMD_FREE) begin
                  // head RAM read of the handle is issued here
                  state_in = ST_HEAD_CHK;
               end else if (req_request_size == '0) begin
                  status_in = STATUS_ZERO_SIZE;
                  rd_ptr_in = '0;
                  free_cnt_in = '0;
                  state_in  = ST_COUNT;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = req_request_size;
                  state_in         = ST_DIV;
               end
            end
         end

         ST_HEAD_CHK: begin
            if (!head_rd[HEAD_W-1]) begin
               status_in   = STATUS_BAD_HANDLE;
               rd_ptr_in   = '0;
               free_cnt_in = '0;
               state_in    = ST_COUNT;
            end else begin
               // drop the head mark and size the run to release
               head_we          = 1'b1;
               head_wa          = handle_ff;
               head_wd          = '0;
               div_req.start    = 1'b1;
               div_req.dividend = head_rd[SIZE_W-1:0];
               state_in         = ST_DIV;
            end
         end

         ST_DIV: begin
            if (div_rsp.done) begin
               need_in = div_rsp.quotient;
               if (cmd_ff == CMD_FREE) begin
                  wa_in       = {1'b0, handle_ff};
                  bytes_in    = (size_ff < bytes_ff) ?
                                bytes_ff - BYTES_W'(size_ff) : '0;
                  free_tot_in = free_tot_ff + 1'b1;
                  state_in    = ST_RELEASE;
               end else if (div_rsp.quotient > SIZE_W'(pool_eff)) begin
                  status_in   = STATUS_NO_FIT;
                  rd_ptr_in   = '0;
                  free_cnt_in = '0;
                  state_in    = ST_COUNT;
               end else begin
                  rd_ptr_in = '0;
                  run_in    = '0;
                  state_in  = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            // issue one flag read per cycle, check the one read before
            if (rd_ptr_ff < pool_eff) begin
               pend_in    = 1'b1;
               rd_ptr_in  = rd_ptr_ff + 1'b1;
               chk_idx_in = rd_ptr_ff[IDX_W-1:0];
            end
            if (pend_ff) begin
               run_in = run_next;
               if (SIZE_W'(run_next) == need_ff) begin
                  pend_in        = 1'b0;
                  start_in       = start_calc[IDX_W-1:0];
                  wa_in          = start_calc;
                  head_we        = 1'b1;
                  head_wa        = start_calc[IDX_W-1:0];
                  head_wd        = {1'b1, size_ff};
                  bytes_in       = bytes_sum[BYTES_W] ? BYTES_MAX : bytes_sum[BYTES_W-1:0];
                  peak_in        = (bytes_in > peak_ff) ? bytes_in : peak_ff;
                  alloc_cnt_in   = alloc_cnt_ff + 1'b1;
                  serial_in      = next_serial_ff;
                  next_serial_in = next_serial_ff + 1'b1;
                  state_in       = ST_MARK;
               end
            end else if (rd_ptr_ff >= pool_eff) begin
               status_in   = STATUS_NO_FIT;
               rd_ptr_in   = '0;
               free_cnt_in = '0;
               state_in    = ST_COUNT;
            end
         end

         ST_MARK: begin
            if (need_ff == '0) begin
               rd_ptr_in   = '0;
               free_cnt_in = '0;
               state_in    = ST_COUNT;
            end else begin
               busy_we = 1'b1;
               busy_wd = 1'b1;
               wa_in   = wa_ff + 1'b1;
               need_in = need_ff - 1'b1;
            end
         end

         ST_RELEASE: begin
            // stop at the run length or at the end of the flag RAM
            if (need_ff == '0 || wa_ff == CNT_W'(NUM_BLOCKS)) begin
               rd_ptr_in   = '0;
               free_cnt_in = '0;
               state_in    = ST_COUNT;
            end else begin
               busy_we = 1'b1;
               busy_wd = 1'b0;
               wa_in   = wa_ff + 1'b1;
               need_in = need_ff - 1'b1;
            end
         end

         ST_COUNT: begin
            if (rd_ptr_ff < pool_eff) begin
               pend_in   = 1'b1;
               rd_ptr_in = rd_ptr_ff + 1'b1;
            end
            if (pend_ff) begin
               if (!busy_rd) begin
                  free_cnt_in = free_cnt_ff + 1'b1;
               end
            end else if (rd_ptr_ff >= pool_eff) begin
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_start_in  = start_ff;
               rsp_serial_in = serial_ff;
               rsp_free_in   = free_cnt_ff;
               rsp_bytes_in  = bytes_ff;
               rsp_peak_in   = peak_ff;
               rsp_alloc_in  = alloc_cnt_ff;
               rsp_ftot_in   = free_tot_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         wa_ff          <= '0;
         pend_ff        <= 1'b0;
         bytes_ff       <= '0;
         peak_ff        <= '0;
         alloc_cnt_ff   <= '0;
         free_tot_ff    <= '0;
         next_serial_ff <= SERIAL_W'(1);
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         wa_ff          <= wa_in;
         pend_ff        <= pend_in;
         bytes_ff       <= bytes_in;
         peak_ff        <= peak_in;
         alloc_cnt_ff   <= alloc_cnt_in;
         free_tot_ff    <= free_tot_in;
         next_serial_ff <= next_serial_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      size_ff       <= size_in;
      handle_ff     <= handle_in;
      need_ff       <= need_in;
      rd_ptr_ff     <= rd_ptr_in;
      chk_idx_ff    <= chk_idx_in;
      run_ff        <= run_in;
      free_cnt_ff   <= free_cnt_in;
      status_ff     <= status_in;
      start_ff      <= start_in;
      serial_ff     <= serial_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_serial_ff <= rsp_serial_in;
      rsp_free_ff   <= rsp_free_in;
      rsp_bytes_ff  <= rsp_bytes_in;
      rsp_peak_ff   <= rsp_peak_in;
      rsp_alloc_ff  <= rsp_alloc_in;
      rsp_ftot_ff   <= rsp_ftot_in;
   end

   // configuration registers; the user must write them only while idle, the block does not enforce it
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bs_ff   <= BLOCK_SIZE_RESET;
         pool_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_BLOCK_SIZE:  bs_ff   <= csr_data[BS_W-1:0];
            CSR_POOL_BLOCKS: pool_ff <= csr_data[CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_start_block       = rsp_start_ff;
   assign rsp_allocation_number = rsp_serial_ff;
   assign rsp_free_block_count  = rsp_free_ff;
   assign rsp_bytes_allocated   = rsp_bytes_ff;
   assign rsp_bytes_peak        = rsp_peak_ff;
   assign rsp_alloc_total       = rsp_alloc_ff;
   assign rsp_free_total        = rsp_ftot_ff;

endmodule

// File: rtl/cba_checker.sv
// ----------------------------------------------------------------------------
// cba_checker
// Port-level checks of the contiguous block allocator.
// ----------------------------------------------------------------------------
module cba_checker
(
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [1:0]                rsp_status,
   input logic [cba_pkg::IDX_W-1:0] rsp_start_block,
   input logic [31:0]               rsp_allocation_number,
   input logic [cba_pkg::CNT_W-1:0] rsp_free_block_count,
   input logic [39:0]               rsp_bytes_allocated,
   input logic [39:0]               rsp_bytes_peak
);
   import cba_pkg::*;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_fail_no_handle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |->
         rsp_start_block == '0 && rsp_allocation_number == '0)
      else $error("failed item carries an allocation");

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_free_block_count <= CNT_W'(NUM_BLOCKS))
      else $error("free count above pool size");

   a_peak_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_bytes_peak >= rsp_bytes_allocated)
      else $error("peak below allocated total");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("stalled result changed");

endmodule

bind contiguous_block_allocator cba_checker u_cba_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_valid),
   .rsp_stall             (rsp_stall),
   .rsp_status            (rsp_status),
   .rsp_start_block       (rsp_start_block),
   .rsp_allocation_number (rsp_allocation_number),
   .rsp_free_block_count  (rsp_free_block_count),
   .rsp_bytes_allocated   (rsp_bytes_allocated),
   .rsp_bytes_peak        (rsp_bytes_peak)
);

// File: dv/tb_contiguous_block_allocator.sv
// ----------------------------------------------------------------------------
// tb_contiguous_block_allocator
// Self-checking bench for the first-fit block allocator. A scoreboard class
// keeps its own copy of the block flags, recorded sizes, byte totals and
// counters. It predicts every result from the accepted items and checks the
// results in order. Directed items cover the corner cases. Random phases
// then run allocate/free traffic over several register settings, with
// idling on both sides.
// ----------------------------------------------------------------------------
module tb_contiguous_block_allocator;
   import cba_pkg::*;

   typedef struct {
      status_type  status;
      logic [9:0]  start_block;
      logic [31:0] alloc_number;
      logic [10:0] free_blocks;
      logic [39:0] bytes_now;
      logic [39:0] bytes_top;
      logic [31:0] allocs;
      logic [31:0] frees;
   } alloc_result_type;

   // Pool model: predicts one result per accepted item and queues it.
   class alloc_scoreboard;
      bit          busy[NUM_BLOCKS];
      bit          head[NUM_BLOCKS];
      bit [31:0]   head_bytes[NUM_BLOCKS];
      bit [24:0]   blk_bytes;
      bit [10:0]   pool_reg;
      bit [39:0]   bytes_now, bytes_top;
      bit [31:0]   allocs, frees, serial_next;
      alloc_result_type pending[$];
      int          errors;
      int          seen[4];

      function new();
         blk_bytes   = BLOCK_SIZE_RESET;
         pool_reg    = '0;
         bytes_now   = '0;
         bytes_top   = '0;
         allocs      = '0;
         frees       = '0;
         serial_next = 32'd1;
         errors      = 0;
         foreach (busy[i]) begin
            busy[i] = 0;
            head[i] = 0;
            head_bytes[i] = '0;
         end
         foreach (seen[i]) seen[i] = 0;
      endfunction

      function void set_reg(csr_index_type idx, bit [24:0] value);
         if (idx == CSR_BLOCK_SIZE) blk_bytes = value;
         else                       pool_reg  = value[10:0];
      endfunction

      function longint unsigned eff_block();
         return (blk_bytes == 0) ? 1 : longint'(blk_bytes);
      endfunction

      function int unsigned eff_pool();
         return (pool_reg > NUM_BLOCKS) ? NUM_BLOCKS : pool_reg;
      endfunction

      function longint unsigned blocks_for(bit [31:0] bytes);
         longint unsigned bs;
         bs = eff_block();
         return (longint'(bytes) + bs - 1) / bs;
      endfunction

      // First live allocation at or after a random point, wrapping around, or -1.
      function int pick_live();
         int base;
         base = $urandom_range(NUM_BLOCKS - 1);
         for (int k = 0; k < NUM_BLOCKS; k++)
            if (head[(base + k) % NUM_BLOCKS]) return (base + k) % NUM_BLOCKS;
         return -1;
      endfunction

      function void note_request(cmd_type cmd, bit [31:0] bytes, bit [9:0] handle);
         alloc_result_type r;
         longint unsigned need, cnt, sum;
         int unsigned    run, pool;
         bit             found;
         r.status = STATUS_OK;
         r.start_block = '0;
         r.alloc_number = '0;
         if (cmd == CMD_ALLOC) begin
            if (bytes == 0) begin
               r.status = STATUS_ZERO_SIZE;
            end else begin
               need  = blocks_for(bytes);
               pool  = eff_pool();
               run   = 0;
               found = 0;
               if (need <= pool) begin
                  for (int i = 0; i < pool && !found; i++) begin
                     run = busy[i] ? 0 : run + 1;
                     if (run == need) begin
                        r.start_block = 10'(i + 1 - run);
                        found = 1;
                     end
                  end
               end
               if (!found) begin
                  r.status = STATUS_NO_FIT;
                  r.start_block = '0;
               end else begin
                  for (int i = 0; i < need; i++) busy[r.start_block + i] = 1;
                  head[r.start_block] = 1;
                  head_bytes[r.start_block] = bytes;
                  sum = longint'(bytes_now) + bytes;
                  bytes_now = (sum > BYTES_MAX) ? BYTES_MAX : sum[39:0];
                  if (bytes_now > bytes_top) bytes_top = bytes_now;
                  allocs++;
                  r.alloc_number = serial_next;
                  serial_next++;
               end
            end
         end else begin
            if (!head[handle]) begin
               r.status = STATUS_BAD_HANDLE;
            end else begin
               // run length comes from the recorded size under the current block size
               cnt = blocks_for(head_bytes[handle]);
               for (longint unsigned k = 0; k < cnt && handle + k < NUM_BLOCKS; k++)
                  busy[handle + k] = 0;
               head[handle] = 0;
               bytes_now -= (bytes < bytes_now) ? bytes : bytes_now;
               frees++;
            end
         end
         r.free_blocks = '0;
         for (int i = 0; i < eff_pool(); i++) if (!busy[i]) r.free_blocks++;
         r.bytes_now = bytes_now;
         r.bytes_top = bytes_top;
         r.allocs    = allocs;
         r.frees     = frees;
         seen[r.status]++;
         pending.insert(pending.size(), r);
      endfunction

      function void compare(string field, longint unsigned exp, longint unsigned act);
         if (exp != act) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp, act);
         end
      endfunction

      function void check_result(alloc_result_type got);
         alloc_result_type e;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: result with no pending expectation, expected none, got status %0d",
                     $time, got.status);
            return;
         end
         e = pending.pop_front();
         compare("status",            e.status,       got.status);
         compare("start_block",       e.start_block,  got.start_block);
         compare("allocation_number", e.alloc_number, got.alloc_number);
         compare("free_block_count",  e.free_blocks,  got.free_blocks);
         compare("bytes_allocated",   e.bytes_now,    got.bytes_now);
         compare("bytes_peak",        e.bytes_top,    got.bytes_top);
         compare("alloc_total",       e.allocs,       got.allocs);
         compare("free_total",        e.frees,        got.frees);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_command = 1'b0;
   logic [31:0] req_request_size = '0;
   logic [9:0]  req_handle_index = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [9:0]  rsp_start_block;
   logic [31:0] rsp_allocation_number;
   logic [10:0] rsp_free_block_count;
   logic [39:0] rsp_bytes_allocated;
   logic [39:0] rsp_bytes_peak;
   logic [31:0] rsp_alloc_total;
   logic [31:0] rsp_free_total;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [24:0] csr_data = '0;

   alloc_scoreboard pool_sb = new();
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int n_items = 0;

   contiguous_block_allocator dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_command, .req_request_size, .req_handle_index,
      .rsp_valid, .rsp_stall, .rsp_status, .rsp_start_block, .rsp_allocation_number,
      .rsp_free_block_count, .rsp_bytes_allocated, .rsp_bytes_peak,
      .rsp_alloc_total, .rsp_free_total,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Result side: check each accepted result, then pick the next stall.
   always @(posedge clock) begin
      alloc_result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.status       = status_type'(rsp_status);
         got.start_block  = rsp_start_block;
         got.alloc_number = rsp_allocation_number;
         got.free_blocks  = rsp_free_block_count;
         got.bytes_now    = rsp_bytes_allocated;
         got.bytes_top    = rsp_bytes_peak;
         got.allocs       = rsp_alloc_total;
         got.frees        = rsp_free_total;
         pool_sb.check_result(got);
      end
      rsp_stall <= ($urandom_range(99) < rx_idle_pct);
   end

   // Drive one item; idle first at random, then hold it until taken.
   task automatic send_item(cmd_type cmd, bit [31:0] bytes, bit [9:0] handle);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_request_size <= bytes;
      req_handle_index <= handle;
      do @(posedge clock); while (req_stall);
      pool_sb.note_request(cmd, bytes, handle);
      n_items++;
   endtask

   // Drop valid and hold off until every pending result is back.
   task automatic drain();
      req_valid <= 1'b0;
      while (pool_sb.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, bit [24:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      pool_sb.set_reg(idx, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly allocations of one to six blocks and frees of live runs;
   // the rest are zero sizes, huge sizes and frees of random handles.
   task automatic random_items(int count);
      int          pick, live;
      longint unsigned bs, bytes;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         bs   = pool_sb.eff_block();
         live = pool_sb.pick_live();
         if (pick < 50) begin
            bytes = ($urandom_range(1, 6) - 1) * bs + $urandom_range(1, int'(bs));
            send_item(CMD_ALLOC, bytes[31:0], 10'($urandom));
         end else if (pick < 55) begin
            send_item(CMD_ALLOC, $urandom, 10'($urandom));
         end else if (pick < 58) begin
            send_item(CMD_ALLOC, 32'd0, 10'($urandom));
         end else if (pick < 92 && live >= 0) begin
            bytes = (pick < 88) ? 64'(pool_sb.head_bytes[live]) : 64'($urandom);
            send_item(CMD_FREE, bytes[31:0], live[9:0]);
         end else begin
            send_item(CMD_FREE, $urandom, 10'($urandom));
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: pool of zero blocks.
      send_item(CMD_ALLOC, 32'd0, 10'd0);
      send_item(CMD_ALLOC, 32'd1, 10'd0);
      send_item(CMD_FREE, 32'd5, 10'd0);
      drain();

      // Zero block size acts as one byte; oversized pool is capped.
      write_reg(CSR_BLOCK_SIZE, 25'd0);
      write_reg(CSR_POOL_BLOCKS, 25'h7FF);
      send_item(CMD_ALLOC, 32'hFFFF_FFFF, 10'h3FF);
      send_item(CMD_ALLOC, 32'd1024, 10'd0);
      send_item(CMD_ALLOC, 32'd1, 10'd0);
      send_item(CMD_FREE, 32'hFFFF_FFFF, 10'd0);
      send_item(CMD_FREE, 32'd1, 10'h3FF);
      send_item(CMD_ALLOC, 32'd1, 10'd0);
      send_item(CMD_ALLOC, 32'd1023, 10'd0);
      send_item(CMD_FREE, 32'd0, 10'd0);
      drain();

      // Largest block size; a run freed under a different block size.
      write_reg(CSR_BLOCK_SIZE, 25'h1FF_FFFF);
      write_reg(CSR_POOL_BLOCKS, 25'd300);
      send_item(CMD_ALLOC, 32'hFFFF_FFFF, 10'd0);
      send_item(CMD_ALLOC, 32'h8000_0000, 10'd0);
      drain();
      write_reg(CSR_BLOCK_SIZE, 25'd1);
      send_item(CMD_FREE, 32'd7, 10'd1);
      send_item(CMD_FREE, 32'd7, 10'd1023);
      send_item(CMD_FREE, 32'h1234, 10'd129);
      drain();

      write_reg(CSR_POOL_BLOCKS, 25'd1024);
      random_items(20);
      drain();

      tx_idle_pct = 36; rx_idle_pct = 60;
      write_reg(CSR_BLOCK_SIZE, 25'd16);
      write_reg(CSR_POOL_BLOCKS, 25'd48);
      random_items(180);
      drain();

      tx_idle_pct = 60; rx_idle_pct = 36;
      write_reg(CSR_BLOCK_SIZE, 25'($urandom_range(2, 25'h1FF_FFFF)));
      write_reg(CSR_POOL_BLOCKS, 25'd24);
      random_items(170);
      drain();

      tx_idle_pct = 0; rx_idle_pct = 0;
      write_reg(CSR_BLOCK_SIZE, 25'd4096);
      write_reg(CSR_POOL_BLOCKS, 25'd64);
      random_items(190);
      drain();

      repeat (100) @(posedge clock);
      if (pool_sb.pending.size() != 0) begin
         pool_sb.errors++;
         $display("%0t: %0d expected results never arrived", $time, pool_sb.pending.size());
      end
      $display("Ran %0d items over six register settings, three idling mixes.", n_items);
      $display("Results: %0d ok, %0d zero size, %0d no fit, %0d unknown handle.",
               pool_sb.seen[0], pool_sb.seen[1], pool_sb.seen[2], pool_sb.seen[3]);
      if (pool_sb.errors == 0) begin
         $display("** contiguous_block_allocator: PASSED **");
      end else begin
         $display("** contiguous_block_allocator: FAILED **");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #100_000_000;
      $display("** contiguous_block_allocator: FAILED **");
      $finish;
   end

endmodule
